[src/rmaa_pkg.sv]
// shared widths, types and arctangent constants for the axial vector converter
package rmaa_pkg;

    localparam int FRAC_BITS    = 30;
    localparam int IN_W         = 32;
    localparam int OUT_W        = 32;
    localparam int NUM_IN       = 9;
    localparam int NUM_OUT      = 3;
    localparam int MAG_W        = 32;
    localparam int SUM_W        = 64;
    localparam int S2_W         = 32;
    localparam int C2_W         = 34;
    localparam int CW           = 64;
    localparam int SH_W         = 6;
    localparam int P_W          = 34;
    localparam int R_W          = 32;
    localparam int PROD_W       = R_W + P_W;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 60;
    localparam int ANG_FRAC     = 60;
    localparam int NORM_TOP     = 59;
    localparam int ROUND_SH     = ANG_FRAC - 31;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 4;
    localparam int DIV_STEPS    = R_W;
    localparam int DIV_PAD      = CORDIC_LAT - DIV_STEPS;
    localparam int OUT_SHIFT    = 63 - FRAC_BITS;

    // sign and zero flags that ride alongside the angle
    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } flags_t;

    // component magnitudes and signs after prescale
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } side_t;

    // shift-subtract division, evaluated only when building constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/n) in Q.62 by truncated series
    function automatic logic signed [63:0] atan_inv_q62(input logic [63:0] n);
        logic [63:0]        p;
        logic [63:0]        term;
        logic signed [63:0] acc;
        p   = udiv64(64'h4000_0000_0000_0000, n);
        acc = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != '0) begin
                term = udiv64(p, 64'(2 * k + 1));
                if (k[0]) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
                p = udiv64(udiv64(p, n), n);
            end
        end
        return acc;
    endfunction

    // rotation angle of cordic step i in Q.60
    function automatic logic signed [63:0] atan_entry(input int i);
        logic signed [63:0] a;
        if (i == 0) begin
            a = 64'sd4 * atan_inv_q62(64'd5) - atan_inv_q62(64'd239);
        end else begin
            a = atan_inv_q62(64'(1) << i);
        end
        return (a + 64'sd2) >>> 2;
    endfunction

endpackage

[src/rmaa_front.sv]
// front end: antisymmetric differences, prescale, squares and their sum
module rmaa_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic [rmaa_pkg::NUM_IN-1:0][rmaa_pkg::IN_W-1:0] mat,
    output logic                                    out_valid,
    output logic [rmaa_pkg::SUM_W-1:0]              sum,
    output logic                                    zero,
    output rmaa_pkg::side_t                         side,
    output logic signed [rmaa_pkg::C2_W-1:0]        c2
);
    import rmaa_pkg::*;

    localparam logic signed [C2_W-1:0] ONE_Q   = C2_W'(1) << FRAC_BITS;
    localparam logic [IN_W:0]          MAG_LIM = (IN_W + 1)'(1) << (IN_W - 1);

    logic signed [IN_W:0]   v [3];
    logic [IN_W:0]          vmag [3];
    logic signed [IN_W:0]   vs [3];
    logic signed [C2_W-1:0] c2_full;
    logic                   big;
    side_t                  side_next;
    logic signed [C2_W-1:0] c2_next;

    side_t                  side1_reg, side2_reg, side3_reg;
    logic signed [C2_W-1:0] c21_reg, c22_reg, c23_reg;
    logic [SUM_W-1:0]       sq_reg [3];
    logic [SUM_W-1:0]       sum_reg;
    logic                   zero_reg;
    logic [2:0]             valid_reg;
    logic [SUM_W-1:0]       sq_next [3];
    logic [SUM_W-1:0]       sum_next;

    // differences, trace and the halving prescale
    always_comb begin
        v[0] = (IN_W + 1)'($signed(mat[5])) - (IN_W + 1)'($signed(mat[7]));
        v[1] = (IN_W + 1)'($signed(mat[6])) - (IN_W + 1)'($signed(mat[2]));
        v[2] = (IN_W + 1)'($signed(mat[1])) - (IN_W + 1)'($signed(mat[3]));
        c2_full = C2_W'($signed(mat[0])) + C2_W'($signed(mat[4]))
                + C2_W'($signed(mat[8])) - ONE_Q;
        big = 1'b0;
        for (int j = 0; j < 3; j++) begin
            vmag[j] = v[j][IN_W] ? $unsigned(-v[j]) : $unsigned(v[j]);
            if (vmag[j] > MAG_LIM) begin
                big = 1'b1;
            end
        end
        c2_next = big ? (c2_full >>> 1) : c2_full;
        for (int j = 0; j < 3; j++) begin
            vs[j]               = big ? (v[j] >>> 1) : v[j];
            side_next.neg[j]    = vs[j][IN_W];
            side_next.mag[j]    = MAG_W'(vs[j][IN_W] ? $unsigned(-vs[j]) : $unsigned(vs[j]));
        end
    end

    // squares and sum
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sq_next[j] = side1_reg.mag[j] * side1_reg.mag[j];
        end
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side_next;
            c21_reg   <= c2_next;
            side2_reg <= side1_reg;
            c22_reg   <= c21_reg;
            for (int j = 0; j < 3; j++) begin
                sq_reg[j] <= sq_next[j];
            end
            side3_reg <= side2_reg;
            c23_reg   <= c22_reg;
            sum_reg   <= sum_next;
            zero_reg  <= (sum_next == '0);
        end
    end

    assign out_valid = valid_reg[2];
    assign sum       = sum_reg;
    assign zero      = zero_reg;
    assign side      = side3_reg;
    assign c2        = c23_reg;

endmodule

[src/rmaa_isqrt.sv]
// pipelined integer square root, one result bit per stage
module rmaa_isqrt (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [rmaa_pkg::SUM_W-1:0]       sum,
    input  logic                             zero_in,
    input  rmaa_pkg::side_t                  side_in,
    input  logic signed [rmaa_pkg::C2_W-1:0] c2_in,
    output logic                             out_valid,
    output logic [rmaa_pkg::S2_W-1:0]        s2,
    output logic                             zero_out,
    output rmaa_pkg::side_t                  side_out,
    output logic signed [rmaa_pkg::C2_W-1:0] c2_out
);
    import rmaa_pkg::*;

    logic [SUM_W-1:0]       n_reg    [SQRT_STEPS];
    logic [SUM_W-1:0]       r_reg    [SQRT_STEPS];
    logic                   zero_reg [SQRT_STEPS];
    side_t                  side_reg [SQRT_STEPS];
    logic signed [C2_W-1:0] c2_reg   [SQRT_STEPS];
    logic [SQRT_STEPS-1:0]  valid_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << (SUM_W - 2 - 2 * k);

        logic [SUM_W-1:0]       n_in, r_in, trial, n_next, r_next;
        logic                   v_in, z_in;
        side_t                  sd_in;
        logic signed [C2_W-1:0] c_in;

        if (k == 0) begin : g_first
            assign n_in  = sum;
            assign r_in  = '0;
            assign v_in  = in_valid;
            assign z_in  = zero_in;
            assign sd_in = side_in;
            assign c_in  = c2_in;
        end else begin : g_rest
            assign n_in  = n_reg[k-1];
            assign r_in  = r_reg[k-1];
            assign v_in  = valid_reg[k-1];
            assign z_in  = zero_reg[k-1];
            assign sd_in = side_reg[k-1];
            assign c_in  = c2_reg[k-1];
        end

        // trial subtract for one root bit
        always_comb begin
            trial = r_in + ONE;
            if (n_in >= trial) begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + ONE;
            end else begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= n_next;
                r_reg[k]    <= r_next;
                zero_reg[k] <= z_in;
                side_reg[k] <= sd_in;
                c2_reg[k]   <= c_in;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign s2        = r_reg[SQRT_STEPS-1][S2_W-1:0];
    assign zero_out  = zero_reg[SQRT_STEPS-1];
    assign side_out  = side_reg[SQRT_STEPS-1];
    assign c2_out    = c2_reg[SQRT_STEPS-1];

endmodule

[src/rmaa_cordic.sv]
// normalisation and pipelined cordic vectoring for the rotation angle
module rmaa_cordic (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [rmaa_pkg::S2_W-1:0]        s2,
    input  logic signed [rmaa_pkg::C2_W-1:0] c2,
    input  rmaa_pkg::flags_t                 flags_in,
    output logic                             out_valid,
    output logic [rmaa_pkg::P_W-1:0]         p,
    output rmaa_pkg::flags_t                 flags_out
);
    import rmaa_pkg::*;

    localparam logic signed [CW-1:0] HALF_PI  = atan_entry(0) <<< 1;
    localparam logic [CW-1:0]        RND_HALF = CW'(1) << (ROUND_SH - 1);

    // normalise: leading one search
    logic [C2_W-1:0]        c2_mag, mx;
    logic [SH_W-1:0]        msb, k_next;
    logic signed [C2_W-1:0] na_reg;
    logic [S2_W-1:0]        nb_reg;
    logic [SH_W-1:0]        k_reg;
    flags_t                 nf1_reg;
    logic                   nv1_reg;

    always_comb begin
        c2_mag = c2[C2_W-1] ? $unsigned(-c2) : $unsigned(c2);
        mx     = (c2_mag > C2_W'(s2)) ? c2_mag : C2_W'(s2);
        msb    = '0;
        for (int b = 0; b < C2_W; b++) begin
            if (mx[b]) begin
                msb = SH_W'(b);
            end
        end
        k_next = SH_W'(NORM_TOP) - msb;
    end

    // normalise: shift both coordinates
    logic signed [CW-1:0] sa_reg, sb_reg;
    flags_t               nf2_reg;
    logic                 nv2_reg;

    // pre-rotation into the right half plane
    logic signed [CW-1:0] pa_next, pb_next, pang_next;
    logic signed [CW-1:0] a_reg   [CORDIC_STEPS+1];
    logic signed [CW-1:0] b_reg   [CORDIC_STEPS+1];
    logic signed [CW-1:0] ang_reg [CORDIC_STEPS+1];
    flags_t               f_reg   [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] v_reg;

    always_comb begin
        if (sa_reg < 0) begin
            pa_next   = sb_reg;
            pb_next   = -sa_reg;
            pang_next = HALF_PI;
        end else begin
            pa_next   = sa_reg;
            pb_next   = sb_reg;
            pang_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv1_reg  <= 1'b0;
            nv2_reg  <= 1'b0;
            v_reg[0] <= 1'b0;
        end else if (en) begin
            nv1_reg  <= in_valid;
            nv2_reg  <= nv1_reg;
            v_reg[0] <= nv2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            na_reg     <= c2;
            nb_reg     <= s2;
            k_reg      <= k_next;
            nf1_reg    <= flags_in;
            sa_reg     <= CW'(na_reg) <<< k_reg;
            sb_reg     <= CW'(nb_reg) << k_reg;
            nf2_reg    <= nf1_reg;
            a_reg[0]   <= pa_next;
            b_reg[0]   <= pb_next;
            ang_reg[0] <= pang_next;
            f_reg[0]   <= nf2_reg;
        end
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [CW-1:0] T_I = atan_entry(i);

        logic signed [CW-1:0] da, db, a_next, b_next, ang_next;

        always_comb begin
            da = b_reg[i] >>> i;
            db = a_reg[i] >>> i;
            if (!b_reg[i][CW-1]) begin
                a_next   = a_reg[i] + da;
                b_next   = b_reg[i] - db;
                ang_next = ang_reg[i] + T_I;
            end else begin
                a_next   = a_reg[i] - da;
                b_next   = b_reg[i] + db;
                ang_next = ang_reg[i] - T_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[i+1]   <= a_next;
                b_reg[i+1]   <= b_next;
                ang_reg[i+1] <= ang_next;
                f_reg[i+1]   <= f_reg[i];
            end
        end
    end

    // clamp and round the angle to Q.31
    logic [CW-1:0]  ang_pos;
    logic [P_W-1:0] p_next;
    logic [P_W-1:0] p_reg;
    flags_t         pf_reg;
    logic           pv_reg;

    always_comb begin
        ang_pos = ang_reg[CORDIC_STEPS][CW-1] ? '0 : $unsigned(ang_reg[CORDIC_STEPS]);
        p_next  = P_W'((ang_pos + RND_HALF) >> ROUND_SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg  <= p_next;
            pf_reg <= f_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = pv_reg;
    assign p         = p_reg;
    assign flags_out = pf_reg;

endmodule

[src/rmaa_divide.sv]
// three-lane restoring divider for |v|/s2 in Q.31, delayed to match the angle
module rmaa_divide (
    input  logic                                         aclk,
    input  logic                                         en,
    input  logic [2:0][rmaa_pkg::MAG_W-1:0]              mag,
    input  logic [rmaa_pkg::S2_W-1:0]                    s2,
    output logic [2:0][rmaa_pkg::R_W-1:0]                r
);
    import rmaa_pkg::*;

    logic [2:0][SUM_W-1:0] num;
    logic [2:0][S2_W-1:0]  rem_reg [DIV_STEPS];
    logic [2:0][R_W-1:0]   low_reg [DIV_STEPS];
    logic [2:0][R_W-1:0]   q_reg   [DIV_STEPS];
    logic [S2_W-1:0]       d_reg   [DIV_STEPS];
    logic [2:0][R_W-1:0]   pad_reg [DIV_PAD];

    // rounded dividend: |v| * 2^31 + s2 / 2
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            num[j] = (SUM_W'(mag[j]) << 31) + SUM_W'(s2 >> 1);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [2:0][S2_W-1:0] rem_in, rem_next;
        logic [2:0][R_W-1:0]  low_in, q_in, q_next;
        logic [S2_W-1:0]      d_in;
        logic [S2_W:0]        t [3];

        if (k == 0) begin : g_first
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    rem_in[j] = num[j][SUM_W-1:R_W];
                    low_in[j] = num[j][R_W-1:0];
                end
            end
            assign q_in = '0;
            assign d_in = s2;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
        end

        // one quotient bit per lane
        always_comb begin
            for (int j = 0; j < 3; j++) begin
                t[j] = {rem_in[j], low_in[j][R_W-1-k]};
                if (t[j] >= {1'b0, d_in}) begin
                    rem_next[j] = S2_W'(t[j] - {1'b0, d_in});
                    q_next[j]   = {q_in[j][R_W-2:0], 1'b1};
                end else begin
                    rem_next[j] = S2_W'(t[j]);
                    q_next[j]   = {q_in[j][R_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_in;
                q_reg[k]   <= q_next;
                d_reg[k]   <= d_in;
            end
        end
    end

    // delay line to line up with the angle pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            pad_reg[0] <= q_reg[DIV_STEPS-1];
            for (int k = 1; k < DIV_PAD; k++) begin
                pad_reg[k] <= pad_reg[k-1];
            end
        end
    end

    assign r = pad_reg[DIV_PAD-1];

endmodule

[src/rotation_matrix_to_axis_angle_top.sv]
// top level: rotation matrix to axial vector converter with stream ports
// pipeline from input transfer to output: front end, square root, normalise and cordic
//   with the divider alongside, then scale and saturate
// throughput: one matrix per cycle; every stage advances together and holds
//   while the output register is full and not taken
// reset: synchronous active-low aresetn clears all valid bits, payload is not reset
module rotation_matrix_to_axis_angle_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 32 bits each from bit 0
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // axis_x, axis_y, axis_z, 32 bits each from bit 0
    output logic [95:0]  m_axis_tdata
);
    import rmaa_pkg::*;

    localparam logic [OUT_W:0]    POS_LIM  = (OUT_W + 1)'(1) << (OUT_W - 1);
    localparam logic [OUT_W:0]    POS_MAX  = POS_LIM - (OUT_W + 1)'(1);
    localparam logic [OUT_W-1:0]  SAT_MIN  = OUT_W'(POS_LIM);
    localparam logic [OUT_W-1:0]  SAT_MAX  = OUT_W'(POS_MAX);
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (OUT_SHIFT - 1);

    logic en;

    // front end outputs
    logic                   f_valid, f_zero;
    logic [SUM_W-1:0]       f_sum;
    side_t                  f_side;
    logic signed [C2_W-1:0] f_c2;

    // square root outputs
    logic                   q_valid, q_zero;
    logic [S2_W-1:0]        q_s2;
    side_t                  q_side;
    logic signed [C2_W-1:0] q_c2;
    flags_t                 q_flags;

    // angle and ratio
    logic                 c_valid;
    logic [P_W-1:0]       c_p;
    flags_t               c_flags;
    logic [2:0][R_W-1:0]  d_r;

    // pipeline advances when the output register is free or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    rmaa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .mat       (s_axis_tdata),
        .out_valid (f_valid),
        .sum       (f_sum),
        .zero      (f_zero),
        .side      (f_side),
        .c2        (f_c2)
    );

    rmaa_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .sum       (f_sum),
        .zero_in   (f_zero),
        .side_in   (f_side),
        .c2_in     (f_c2),
        .out_valid (q_valid),
        .s2        (q_s2),
        .zero_out  (q_zero),
        .side_out  (q_side),
        .c2_out    (q_c2)
    );

    assign q_flags.zero = q_zero;
    assign q_flags.neg  = q_side.neg;

    rmaa_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .s2        (q_s2),
        .c2        (q_c2),
        .flags_in  (q_flags),
        .out_valid (c_valid),
        .p         (c_p),
        .flags_out (c_flags)
    );

    rmaa_divide u_divide (
        .aclk (aclk),
        .en   (en),
        .mag  (q_side.mag),
        .s2   (q_s2),
        .r    (d_r)
    );

    // scale: ratio times angle
    logic [PROD_W-1:0] prod_reg [3];
    flags_t            mf_reg;
    logic              mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                prod_reg[j] <= PROD_W'(d_r[j]) * PROD_W'(c_p);
            end
            mf_reg <= c_flags;
        end
    end

    // round, apply sign and saturate
    logic [OUT_W:0]                 qm [3];
    logic [NUM_OUT-1:0][OUT_W-1:0]  res_next;
    logic [95:0]                    m_axis_tdata_reg;
    logic                           m_axis_tvalid_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            qm[j] = (OUT_W + 1)'((prod_reg[j] + RND_HALF) >> OUT_SHIFT);
            if (mf_reg.zero) begin
                res_next[j] = '0;
            end else if (mf_reg.neg[j]) begin
                res_next[j] = (qm[j] > POS_LIM) ? SAT_MIN : OUT_W'(-qm[j]);
            end else begin
                res_next[j] = (qm[j] > POS_MAX) ? SAT_MAX : OUT_W'(qm[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_axis_tvalid_reg <= mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_axis_tdata_reg <= res_next;
        end
    end

    assign m_axis_tvalid = m_axis_tvalid_reg;
    assign m_axis_tdata  = m_axis_tdata_reg;

endmodule

[sim/tb_top.sv]
// testbench for the rotation matrix to axial vector converter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmaa_pkg::*;

    typedef logic signed [IN_W-1:0]  elem_t;
    typedef elem_t                   matrix_t [NUM_IN];
    typedef logic [NUM_OUT*OUT_W-1:0] axial_t;

    localparam int ANGLE_STEPS = 60;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;

    longint signed   angle_tab [ANGLE_STEPS];
    axial_t          pending_axials [$];
    int              send_gap_pct = 0;
    int              stall_pct = 0;
    int              n_errors = 0;
    int              n_sent = 0;
    int              n_checked = 0;
    int              n_zero = 0;

    rotation_matrix_to_axis_angle_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // arctangent of 1/n in Q.62 by truncated alternating series
    function automatic longint signed series_atan(longint unsigned n);
        longint unsigned pw;
        longint signed   acc;
        longint unsigned k;
        pw  = (64'd1 << 62) / n;
        acc = 0;
        k   = 0;
        while (pw != 0) begin
            if (k[0]) acc = acc - longint'(pw / (2 * k + 1));
            else acc = acc + longint'(pw / (2 * k + 1));
            pw = pw / n / n;
            k++;
        end
        return acc;
    endfunction

    // integer square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs64(longint signed v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // scale one difference by angle over magnitude, then saturate
    function automatic logic [OUT_W-1:0] scale_component(longint signed v,
            longint unsigned s2, longint unsigned p);
        longint unsigned r, q;
        longint signed   res;
        r = ((abs64(v) << 31) + (s2 >> 1)) / s2;
        q = (r * p + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (v < 0) res = (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
        else res = (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
        return res[OUT_W-1:0];
    endfunction

    // expected axial vector of one matrix
    function automatic axial_t predict_axial(matrix_t mx);
        longint signed   d [3];
        longint signed   c2, va, vb, da, db, ang;
        longint unsigned big, total, s2, p;
        axial_t          res;
        d[0] = longint'(mx[5]) - longint'(mx[7]);
        d[1] = longint'(mx[6]) - longint'(mx[2]);
        d[2] = longint'(mx[1]) - longint'(mx[3]);
        c2   = longint'(mx[0]) + longint'(mx[4]) + longint'(mx[8]) - (64'sd1 << FRAC_BITS);
        big  = 0;
        for (int j = 0; j < 3; j++) if (abs64(d[j]) > big) big = abs64(d[j]);
        // prescale when a difference needs the 33rd bit
        if (big > (64'd1 << 31)) begin
            for (int j = 0; j < 3; j++) d[j] = d[j] >>> 1;
            c2 = c2 >>> 1;
        end
        total = 0;
        for (int j = 0; j < 3; j++) total = total + abs64(d[j]) * abs64(d[j]);
        if (total == 0) return '0;
        s2  = int_sqrt(total);
        // normalise angle vector
        vb  = longint'(s2);
        va  = c2;
        big = abs64(va) > s2 ? abs64(va) : s2;
        while (big >= (64'd1 << 60)) begin
            va = va >>> 1; vb = vb >>> 1; big = big >> 1;
        end
        while (big != 0 && big < (64'd1 << 59)) begin
            va = va * 2; vb = vb * 2; big = big << 1;
        end
        // cordic vectoring, quarter turn first in the left half plane
        ang = 0;
        if (va < 0) begin
            da  = va;
            va  = vb;
            vb  = -da;
            ang = 2 * angle_tab[0];
        end
        for (int i = 0; i < ANGLE_STEPS; i++) begin
            da = vb >>> i;
            db = va >>> i;
            if (vb >= 0) begin
                va = va + da; vb = vb - db; ang = ang + angle_tab[i];
            end else begin
                va = va - da; vb = vb + db; ang = ang - angle_tab[i];
            end
        end
        if (ang < 0) ang = 0;
        p = (longint'(ang) + (64'd1 << 28)) >> 29;
        for (int j = 0; j < 3; j++) res[j*OUT_W +: OUT_W] = scale_component(d[j], s2, p);
        return res;
    endfunction

    // send one matrix, idling first at random
    task automatic send_matrix(matrix_t mx);
        logic [287:0] flat;
        for (int k = 0; k < NUM_IN; k++) flat[k*IN_W +: IN_W] = mx[k];
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= flat;
        do @(posedge aclk); while (!s_axis_tready);
        pending_axials.push_back(predict_axial(mx));
        if (flat[287:0] != '0 && predict_axial(mx) == '0) n_zero++;
        n_sent++;
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // rotation about a random axis, with optional lsb noise
    function automatic matrix_t make_rotation(real t, int noise);
        real ux, uy, uz, nrm, c, s, cc;
        real r [9];
        matrix_t mx;
        ux  = $itor($urandom_range(2000)) - 1000.0;
        uy  = $itor($urandom_range(2000)) - 1000.0;
        uz  = $itor($urandom_range(2000)) - 1000.0;
        nrm = $sqrt(ux*ux + uy*uy + uz*uz);
        if (nrm < 1.0) begin
            ux = 1.0; nrm = 1.0;
        end
        ux = ux / nrm; uy = uy / nrm; uz = uz / nrm;
        c  = $cos(t); s = $sin(t); cc = 1.0 - c;
        r[0] = c + ux*ux*cc;    r[1] = ux*uy*cc - uz*s; r[2] = ux*uz*cc + uy*s;
        r[3] = uy*ux*cc + uz*s; r[4] = c + uy*uy*cc;    r[5] = uy*uz*cc - ux*s;
        r[6] = uz*ux*cc - uy*s; r[7] = uz*uy*cc + ux*s; r[8] = c + uz*uz*cc;
        for (int k = 0; k < 9; k++)
            mx[k] = elem_t'($rtoi(r[k] * 1073741824.0)
                    + (noise > 0 ? $urandom_range(2*noise) - noise : 0));
        return mx;
    endfunction

    function automatic matrix_t make_raw();
        matrix_t mx;
        for (int k = 0; k < 9; k++) mx[k] = elem_t'($urandom);
        return mx;
    endfunction

    function automatic matrix_t fill_all(elem_t v);
        matrix_t mx;
        for (int k = 0; k < 9; k++) mx[k] = v;
        return mx;
    endfunction

    // extremes, identity, half turns and tiny angles
    task automatic test_directed();
        matrix_t mx;
        send_matrix(fill_all('0));
        send_matrix(fill_all(32'sh7FFF_FFFF));
        send_matrix(fill_all(32'sh8000_0000));
        mx = fill_all('0);
        mx[0] = 32'sh4000_0000; mx[4] = 32'sh4000_0000; mx[8] = 32'sh4000_0000;
        send_matrix(mx);
        // half turn about x: zero differences
        mx = fill_all('0);
        mx[0] = 32'sh4000_0000; mx[4] = -32'sh4000_0000; mx[8] = -32'sh4000_0000;
        send_matrix(mx);
        // largest differences in every component, both signs
        mx = fill_all('0);
        mx[5] = 32'sh7FFF_FFFF; mx[7] = 32'sh8000_0000;
        mx[6] = 32'sh8000_0000; mx[2] = 32'sh7FFF_FFFF;
        mx[1] = 32'sh7FFF_FFFF; mx[3] = 32'sh8000_0000;
        send_matrix(mx);
        mx[0] = 32'sh8000_0000; mx[4] = 32'sh8000_0000; mx[8] = 32'sh8000_0000;
        send_matrix(mx);
        mx[5] = 32'sh8000_0000; mx[7] = 32'sh7FFF_FFFF;
        mx[0] = 32'sh7FFF_FFFF; mx[4] = 32'sh7FFF_FFFF; mx[8] = 32'sh7FFF_FFFF;
        send_matrix(mx);
        // one lsb difference
        mx = fill_all('0);
        mx[0] = 32'sh4000_0000; mx[4] = 32'sh4000_0000; mx[8] = 32'sh4000_0000;
        mx[1] = 32'sh1;
        send_matrix(mx);
        // angles from tiny to just short of a half turn
        send_matrix(make_rotation(1.0e-6, 0));
        send_matrix(make_rotation(0.5, 0));
        send_matrix(make_rotation(1.5707963, 0));
        send_matrix(make_rotation(2.5, 0));
        send_matrix(make_rotation(3.1415, 0));
        send_matrix(make_rotation(3.14159265, 0));
        send_matrix(make_rotation(-1.0, 0));
        for (int k = 0; k < 8; k++) send_matrix(make_raw());
        release_bus();
    endtask

    // mostly true rotations, some noisy ones and raw words
    task automatic test_random_mix(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(9);
            if (pick < 5) send_matrix(make_rotation($itor($urandom_range(1000000)) * 3.1415926e-6, 0));
            else if (pick < 7) send_matrix(make_rotation($itor($urandom_range(1000)) * 3.14e-3,
                                                         $urandom_range(1000)));
            else send_matrix(make_raw());
        end
        release_bus();
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each output transfer with the oldest prediction
    always @(posedge aclk) begin
        axial_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            if (pending_axials.size() == 0) begin
                $display("%0t: unexpected transfer, got %h", $realtime, m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_axials.pop_front();
                for (int j = 0; j < NUM_OUT; j++)
                    if (m_axis_tdata[j*OUT_W +: OUT_W] != want[j*OUT_W +: OUT_W]) begin
                        $display("%0t: axis component %0d expected %h got %h", $realtime, j,
                                 want[j*OUT_W +: OUT_W], m_axis_tdata[j*OUT_W +: OUT_W]);
                        n_errors++;
                    end
            end
        end
    end

    initial begin
        #5ms;
        $display("rotation_matrix_to_axis_angle_top: mismatch");
        $finish;
    end

    initial begin
        longint signed a;
        for (int i = 0; i < ANGLE_STEPS; i++) begin
            if (i == 0) a = 4 * series_atan(5) - series_atan(239);
            else a = series_atan(64'd1 << i);
            angle_tab[i] = (a + 2) >>> 2;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_gap_pct = 12; stall_pct = 48;
        test_random_mix(650);
        send_gap_pct = 48; stall_pct = 12;
        test_random_mix(650);
        send_gap_pct = 0; stall_pct = 0;
        test_random_mix(630);
        while (pending_axials.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        $display("sent %0d matrices (directed extremes, rotations, noisy and raw words)",
                 n_sent);
        $display("checked %0d axial vectors, %0d non-trivial inputs gave the zero vector",
                 n_checked, n_zero);
        if (n_errors == 0 && pending_axials.size() == 0) begin
            $display("rotation_matrix_to_axis_angle_top: match");
        end else begin
            $display("rotation_matrix_to_axis_angle_top: mismatch");
        end
        $finish;
    end

endmodule
